FILE: hw/rtl/tti_pkg.sv
// tti_pkg: shared constants, reference resistance table, codes and
// controller/datapath command types for the thermistor table interpolator
// no dependencies
`default_nettype none

package tti_pkg;

   // table and number format
   localparam int TABLE_ENTRIES  = 32;
   localparam int TABLE_CAPACITY = 32;
   localparam int FRACTION_BITS  = 8;
   localparam int BASE_TEMP_F    = -20;
   localparam int STEP_TEMP_F    = 10;

   localparam int RES_W   = 20;
   localparam int TEMP_W  = 18;
   localparam int STAT_W  = 2;
   localparam int REF_W   = 18;
   localparam int IDX_W   = $clog2(TABLE_CAPACITY);
   localparam int POS_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int SCALE   = 1 << FRACTION_BITS;
   localparam int SCALE10 = STEP_TEMP_F * SCALE;
   localparam int QUOT_W  = $clog2(SCALE10 + 1);
   localparam int CNT_W   = $clog2(QUOT_W);
   localparam int NUM_W   = REF_W + QUOT_W;
   localparam int CALC_W  = 24;

   // clamp status codes
   typedef enum logic [STAT_W-1:0] {
      STATUS_INTERP = 2'd0,
      STATUS_COLD   = 2'd1,
      STATUS_HOT    = 2'd2
   } clamp_status_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SETUP,
      ST_DIVIDE,
      ST_FINISH
   } tti_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_input;
      logic search_step;
      logic setup_div;
      logic div_step;
      logic write_out;
   } tti_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic search_last;
      logic div_last;
      logic clamp;
   } tti_sts_type;

   // descending reference resistances, entry i stands for -20 + 10*i F
   function automatic logic [REF_W-1:0] ref_ohms(input logic [IDX_W-1:0] idx);
      logic [REF_W-1:0] val;
      case (idx)
         5'd0:    val = 18'd189726;
         5'd1:    val = 18'd132092;
         5'd2:    val = 18'd93425;
         5'd3:    val = 18'd67059;
         5'd4:    val = 18'd48804;
         5'd5:    val = 18'd35983;
         5'd6:    val = 18'd26855;
         5'd7:    val = 18'd20274;
         5'd8:    val = 18'd15473;
         5'd9:    val = 18'd11929;
         5'd10:   val = 18'd9287;
         5'd11:   val = 18'd7295;
         5'd12:   val = 18'd5781;
         5'd13:   val = 18'd4618;
         5'd14:   val = 18'd3718;
         5'd15:   val = 18'd3016;
         5'd16:   val = 18'd2463;
         5'd17:   val = 18'd2025;
         5'd18:   val = 18'd1675;
         5'd19:   val = 18'd1395;
         5'd20:   val = 18'd1167;
         5'd21:   val = 18'd983;
         5'd22:   val = 18'd832;
         5'd23:   val = 18'd707;
         5'd24:   val = 18'd604;
         5'd25:   val = 18'd519;
         5'd26:   val = 18'd447;
         5'd27:   val = 18'd387;
         5'd28:   val = 18'd336;
         5'd29:   val = 18'd294;
         5'd30:   val = 18'd257;
         5'd31:   val = 18'd226;
         default: val = '0;
      endcase
      return val;
   endfunction

   // segment temperature (base + step*idx) in fixed point
   function automatic logic [CALC_W-1:0] seg_temp(input logic [POS_W-1:0] idx);
      int t;
      t = (BASE_TEMP_F + STEP_TEMP_F * int'(idx)) * SCALE;
      return CALC_W'(t);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tti_if.sv
// tti_req_if and tti_rsp_if: valid/ready channels of the interpolator
// depends on tti_pkg
`default_nettype none

interface tti_req_if;
   logic                       valid;
   logic                       ready;
   logic [tti_pkg::RES_W-1:0]  sense_ohms;

   modport source (output valid, output sense_ohms, input ready);
   modport sink   (input valid, input sense_ohms, output ready);
endinterface

interface tti_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [tti_pkg::TEMP_W-1:0] temperature_q8;
   logic [tti_pkg::STAT_W-1:0]        clamp_status;

   modport source (output valid, output temperature_q8, output clamp_status, input ready);
   modport sink   (input valid, input temperature_q8, input clamp_status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tti_datapath.sv
// tti_datapath: binary table search, constant multiply, restoring divider
// and result register; depends on tti_pkg
`default_nettype none

module tti_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tti_pkg::tti_cmd_type         cmd,
   output tti_pkg::tti_sts_type              sts,
   input  wire logic [tti_pkg::RES_W-1:0]    sense_ohms,
   output logic [tti_pkg::TEMP_W-1:0]        temperature_q8,
   output logic [tti_pkg::STAT_W-1:0]        clamp_status
);

   logic [tti_pkg::RES_W-1:0]   r_ff, r_in;
   logic [tti_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [tti_pkg::POS_W-1:0]   stride_ff, stride_in;
   logic [tti_pkg::NUM_W-1:0]   rem_ff, rem_in;
   logic [tti_pkg::NUM_W-1:0]   dsh_ff, dsh_in;
   logic [tti_pkg::QUOT_W-1:0]  q_ff, q_in;
   logic [tti_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [tti_pkg::TEMP_W-1:0]  temp_ff, temp_in;
   logic [tti_pkg::STAT_W-1:0]  stat_ff, stat_in;

   logic [tti_pkg::POS_W:0]     cand;
   logic [tti_pkg::REF_W-1:0]   probe;
   logic                        take;
   logic [tti_pkg::REF_W-1:0]   below;
   logic [tti_pkg::REF_W-1:0]   above;
   logic [tti_pkg::RES_W-1:0]   diff;
   logic                        is_hot;
   logic                        is_cold;
   logic [tti_pkg::POS_W-1:0]   seg_idx;
   logic [tti_pkg::CALC_W-1:0]  temp_calc;
   logic [tti_pkg::NUM_W-1:0]   rem_sub;
   logic                        fits;

   // search probe: count of entries at or above the input
   assign cand  = {1'b0, pos_ff} + {1'b0, stride_ff};
   assign probe = tti_pkg::ref_ohms(tti_pkg::IDX_W'(cand - 1'b1));
   assign take  = (cand <= (tti_pkg::POS_W+1)'(tti_pkg::TABLE_ENTRIES)) &&
                  ({2'b00, probe} >= r_ff);

   // segment endpoints and clamp decode
   assign below   = tti_pkg::ref_ohms(pos_ff[tti_pkg::IDX_W-1:0]);
   assign above   = tti_pkg::ref_ohms(tti_pkg::IDX_W'(pos_ff - 1'b1));
   assign diff    = r_ff - {2'b00, below};
   assign is_hot  = (pos_ff == tti_pkg::POS_W'(tti_pkg::TABLE_ENTRIES));
   assign is_cold = (pos_ff == '0);

   // divider compare and subtract
   assign fits    = (rem_ff >= dsh_ff);
   assign rem_sub = rem_ff - dsh_ff;

   // final temperature
   assign seg_idx   = is_hot ? tti_pkg::POS_W'(tti_pkg::TABLE_ENTRIES - 1) : pos_ff;
   assign temp_calc = tti_pkg::seg_temp(seg_idx) - tti_pkg::CALC_W'(q_ff);

   // next-state logic
   always_comb begin
      r_in      = r_ff;
      pos_in    = pos_ff;
      stride_in = stride_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      temp_in   = temp_ff;
      stat_in   = stat_ff;
      if (cmd.load_input) begin
         r_in      = sense_ohms;
         pos_in    = '0;
         stride_in = tti_pkg::POS_W'(1) << (tti_pkg::POS_W - 1);
         q_in      = '0;
      end
      if (cmd.search_step) begin
         if (take) begin
            pos_in = cand[tti_pkg::POS_W-1:0];
         end
         stride_in = stride_ff >> 1;
      end
      if (cmd.setup_div) begin
         rem_in = tti_pkg::NUM_W'(diff[tti_pkg::REF_W-1:0]) *
                  tti_pkg::NUM_W'(tti_pkg::SCALE10);
         dsh_in = tti_pkg::NUM_W'(above - below) << (tti_pkg::QUOT_W - 1);
         cnt_in = tti_pkg::CNT_W'(tti_pkg::QUOT_W - 1);
         q_in   = '0;
      end
      if (cmd.div_step) begin
         if (fits) begin
            rem_in = rem_sub;
         end
         q_in   = {q_ff[tti_pkg::QUOT_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.write_out) begin
         temp_in = temp_calc[tti_pkg::TEMP_W-1:0];
         if (is_hot) begin
            stat_in = tti_pkg::STATUS_HOT;
         end else if (is_cold) begin
            stat_in = tti_pkg::STATUS_COLD;
         end else begin
            stat_in = tti_pkg::STATUS_INTERP;
         end
      end
   end

   // step counters
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         stride_ff <= stride_in;
         cnt_ff    <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      r_ff    <= r_in;
      pos_ff  <= pos_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      temp_ff <= temp_in;
      stat_ff <= stat_in;
   end

   // status back to the controller
   assign sts.search_last = (stride_ff == tti_pkg::POS_W'(1));
   assign sts.div_last    = (cnt_ff == '0);
   assign sts.clamp       = is_hot || is_cold;

   assign temperature_q8 = temp_ff;
   assign clamp_status   = stat_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tti_controller.sv
// tti_controller: sequencing state machine and result valid flag
// depends on tti_pkg
`default_nettype none

module tti_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output tti_pkg::tti_cmd_type       cmd,
   input  wire tti_pkg::tti_sts_type  sts
);

   tti_pkg::tti_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   // result register can take a new value
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tti_pkg::ST_IDLE: begin
            if (req_valid) state_in = tti_pkg::ST_SEARCH;
         end
         tti_pkg::ST_SEARCH: begin
            if (sts.search_last) state_in = tti_pkg::ST_SETUP;
         end
         tti_pkg::ST_SETUP: begin
            state_in = sts.clamp ? tti_pkg::ST_FINISH : tti_pkg::ST_DIVIDE;
         end
         tti_pkg::ST_DIVIDE: begin
            if (sts.div_last) state_in = tti_pkg::ST_FINISH;
         end
         tti_pkg::ST_FINISH: begin
            if (out_free) state_in = tti_pkg::ST_IDLE;
         end
         default: state_in = tti_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tti_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load_input = req_valid;
         end
         tti_pkg::ST_SEARCH: begin
            cmd.search_step = 1'b1;
         end
         tti_pkg::ST_SETUP: begin
            cmd.setup_div = !sts.clamp;
         end
         tti_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         tti_pkg::ST_FINISH: begin
            cmd.write_out = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.write_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tti_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.write_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

   // a clamped item skips the divider
   a_clamp_skip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tti_pkg::ST_SETUP && sts.clamp) |=> (state_ff == tti_pkg::ST_FINISH))
      else $error("clamped item entered the divider");

   // the divider is entered only from setup
   a_div_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tti_pkg::ST_DIVIDE && $past(state_ff) != tti_pkg::ST_DIVIDE)
      |-> ($past(state_ff) == tti_pkg::ST_SETUP))
      else $error("divider entered without setup");

   // an accepted item starts the search next cycle
   a_accept_search: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == tti_pkg::ST_SEARCH))
      else $error("accepted item did not start search");

endmodule

`default_nettype wire

FILE: hw/rtl/thermistor_table_interpolator_core.sv
// thermistor_table_interpolator_core: top level, resistance in, temperature out
// depends on tti_pkg, tti_if, tti_controller, tti_datapath
//
// channel    dir  payload                                 transfer
// req_chan   in   sense_ohms[19:0] unsigned               valid & ready
// rsp_chan   out  temperature_q8[17:0] signed Q.8,        valid & ready
//                 clamp_status[1:0]
//
// interpolated item: accept, binary search, divider setup, divide, finish
// clamped item: accept, binary search, setup, finish; the divider is skipped
// the search is a 6-step binary table search and the divide a 12-step restoring divider
// one item at a time; a new item is taken while the last result waits in its register
// reset is synchronous, active high, and clears the state machine and result valid
`default_nettype none

module thermistor_table_interpolator_core (
   input  wire logic  clock,
   input  wire logic  reset,
   tti_req_if.sink    req_chan,
   tti_rsp_if.source  rsp_chan
);

   tti_pkg::tti_cmd_type          cmd;
   tti_pkg::tti_sts_type          sts;
   logic [tti_pkg::TEMP_W-1:0]    temp_bits;

   // sequencing
   tti_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // search, divide and result register
   tti_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .sense_ohms     (req_chan.sense_ohms),
      .temperature_q8 (temp_bits),
      .clamp_status   (rsp_chan.clamp_status)
   );

   assign rsp_chan.temperature_q8 = signed'(temp_bits);

endmodule

`default_nettype wire
